/* design/pmrt_pkg.sv */
package pmrt_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    localparam int ADDR_W  = 64;
    localparam int TYPE_W  = 32;
    localparam int FUNC_W  = 4;
    localparam int INDEX_W = 6;
    localparam int RCNT_W  = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD       = 4'd0,
        FN_LARGEST   = 4'd1,
        FN_RSV_OVL   = 4'd2,
        FN_USABLE_AT = 4'd3,
        FN_READ      = 4'd4,
        FN_TOTAL     = 4'd5,
        FN_END       = 4'd6,
        FN_USE_OVL   = 4'd7,
        FN_ABOVE     = 4'd8
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic wr;
        logic rd_index;
        logic scan;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              scan_last;
    } t_status;

endpackage

/* design/pmrt_ctrl.sv */
module pmrt_ctrl
    import pmrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_status           i_status,
    output t_cmd              o_cmd,
    output logic              busy
);

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_drain;
    logic [1:0] n_drain;
    logic       scan_func;

    // Every command except add, read and unknown codes walks the table.
    always_comb begin
        unique case (i_func)
            FN_LARGEST, FN_RSV_OVL, FN_USABLE_AT, FN_TOTAL,
            FN_END, FN_USE_OVL, FN_ABOVE: scan_func = 1'b1;
            default:                      scan_func = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drain <= 2'd0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = scan_func ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FINISH;
            end
            ST_SCAN: begin
                n_drain = 2'd0;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == DRAIN_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_EXEC: begin
                o_cmd.wr       = (i_status.func == FN_ADD);
                o_cmd.rd_index = (i_status.func == FN_READ);
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_drain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_drain <= DRAIN_LAST))
        else $error("drain counter ran past its end");
`endif

endmodule

/* design/pmrt_dp.sv */
module pmrt_dp
    import pmrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_we,
    input  logic [TYPE_W-1:0]  i_cfg_wdata,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic [ADDR_W-1:0]  i_len,
    input  logic [TYPE_W-1:0]  i_region_kind,
    input  logic [ADDR_W-1:0]  i_base,
    input  logic [ADDR_W-1:0]  i_limit,
    input  logic [INDEX_W-1:0] i_index,
    output logic               o_done,
    output logic               o_ok,
    output logic [ADDR_W-1:0]  o_first_value,
    output logic [ADDR_W-1:0]  o_second_value,
    output logic [TYPE_W-1:0]  o_region_type,
    output logic [RCNT_W-1:0]  o_region_count
);

    // Region table.
    logic [ADDR_W-1:0] mem_start [MAX_REGIONS];
    logic [ADDR_W-1:0] mem_len   [MAX_REGIONS];
    logic [TYPE_W-1:0] mem_code  [MAX_REGIONS];

    logic [TYPE_W-1:0]  r_utype;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ptr;

    // Command word latched at start.
    logic [FUNC_W-1:0]  r_func;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_len;
    logic [TYPE_W-1:0]  r_kind;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_limit;
    logic [INDEX_W-1:0] r_index;
    logic [ADDR_W-1:0]  r_addr_end;
    logic               r_add_ok;
    logic               r_read_ok;

    // Scan pipeline: table read, region end, clipping, accumulate.
    logic               issue;
    logic [IDX_W-1:0]   rd_addr;
    logic               r_v1, r_v2, r_v3;
    logic [ADDR_W-1:0]  r_m_start, r_m_len;
    logic [TYPE_W-1:0]  r_m_code;
    logic [ADDR_W-1:0]  r_b_ra, r_b_rl, r_b_end, r_b_rb, r_b_s8;
    logic               r_b_use;
    logic               c_clip, c_skip, c_hit;
    logic [ADDR_W-1:0]  c_add;
    logic               r_c_take, r_c_hit, r_c_use;
    logic [ADDR_W-1:0]  r_c_rlen, r_c_rb, r_c_e, r_c_add, r_c_end;

    // Accumulators.
    logic               r_hit;
    logic [ADDR_W-1:0]  r_s, r_e, r_blen, r_acc;

    // Result word.
    logic               r_done, r_o_ok;
    logic [ADDR_W-1:0]  r_o_first, r_o_second;
    logic [TYPE_W-1:0]  r_o_type;
    logic               n_ok;
    logic [ADDR_W-1:0]  n_first, n_second;
    logic [TYPE_W-1:0]  n_type;
    logic [31:0]        count32;

    assign issue   = i_cmd.scan && (r_ptr < r_count);
    assign rd_addr = i_cmd.rd_index ? r_index[IDX_W-1:0] : r_ptr[IDX_W-1:0];

    assign o_status.func      = r_func;
    assign o_status.scan_last = ((CNT_W+1)'(r_ptr) + (CNT_W+1)'(1)) >= (CNT_W+1)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utype <= TYPE_W'(1);
            r_count <= '0;
            r_ptr   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_utype <= i_cfg_wdata;
            end
            if (i_cmd.wr && (r_count < CNT_W'(MAX_REGIONS))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            r_v1   <= issue;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (r_count < CNT_W'(MAX_REGIONS))) begin
            mem_start[r_count[IDX_W-1:0]] <= r_addr;
            mem_len[r_count[IDX_W-1:0]]   <= r_len;
            mem_code[r_count[IDX_W-1:0]]  <= r_kind;
        end
        if (issue || i_cmd.rd_index) begin
            r_m_start <= mem_start[rd_addr];
            r_m_len   <= mem_len[rd_addr];
            r_m_code  <= mem_code[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_addr     <= i_addr;
            r_len      <= i_len;
            r_kind     <= i_region_kind;
            r_base     <= i_base;
            r_limit    <= i_limit;
            r_index    <= i_index;
            r_addr_end <= i_addr + i_len;
        end
        if (i_cmd.wr) begin
            r_add_ok <= (r_count < CNT_W'(MAX_REGIONS));
        end
        if (i_cmd.rd_index) begin
            r_read_ok <= (32'(r_index) < 32'(r_count));
        end
    end

    // Region end and the two clip points.
    always_ff @(posedge i_clk) begin
        r_b_ra  <= r_m_start;
        r_b_rl  <= r_m_len;
        r_b_end <= r_m_start + r_m_len;
        r_b_rb  <= (r_m_start < r_base) ? r_base : r_m_start;
        r_b_s8  <= (r_m_start < r_limit) ? r_limit : r_m_start;
        r_b_use <= (r_m_code == r_utype);
    end

    // Since rb + rlen always equals the region end, the clipped length is
    // end - rb, or limit - rb where the end runs past the limit.
    assign c_clip = r_b_end > r_limit;
    assign c_skip = !r_b_use || (r_b_rl == '0) || (r_b_end <= r_base)
                    || (c_clip && (r_b_rb >= r_limit));

    always_comb begin
        c_hit = 1'b0;
        c_add = '0;
        case (r_func)
            FN_RSV_OVL:   c_hit = !r_b_use && (r_addr < r_b_end) && (r_b_ra < r_addr_end);
            FN_USABLE_AT: c_hit = r_b_use && (r_addr >= r_b_ra) && (r_addr < r_b_end);
            FN_USE_OVL:   c_hit = r_b_use && (r_b_ra < r_limit) && (r_b_end > r_base);
            FN_TOTAL:     c_add = r_b_use ? r_b_rl : '0;
            FN_ABOVE:     c_add = (r_b_use && c_clip) ? (r_b_end - r_b_s8) : '0;
            default: begin
                c_hit = 1'b0;
                c_add = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_c_take <= !c_skip;
        r_c_rlen <= c_clip ? (r_limit - r_b_rb) : (r_b_end - r_b_rb);
        r_c_rb   <= r_b_rb;
        r_c_e    <= c_clip ? r_limit : r_b_end;
        r_c_hit  <= c_hit;
        r_c_add  <= c_add;
        r_c_use  <= r_b_use;
        r_c_end  <= r_b_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit  <= 1'b0;
            r_s    <= '0;
            r_e    <= '0;
            r_blen <= '0;
            r_acc  <= '0;
        end else if (r_v3) begin
            r_hit <= r_hit || r_c_hit;
            if ((r_func == FN_LARGEST) && r_c_take && (r_blen < r_c_rlen)) begin
                r_s    <= r_c_rb;
                r_e    <= r_c_e;
                r_blen <= r_c_rlen;
            end
            if (r_func == FN_END) begin
                if (r_c_use && (r_c_end > r_acc)) begin
                    r_acc <= r_c_end;
                end
            end else begin
                r_acc <= r_acc + r_c_add;
            end
        end
    end

    always_comb begin
        n_ok     = 1'b0;
        n_first  = '0;
        n_second = '0;
        n_type   = '0;
        case (r_func)
            FN_ADD: n_ok = r_add_ok;
            FN_LARGEST: begin
                n_ok     = (r_e > r_s) && (r_s != '0);
                n_first  = r_s;
                n_second = r_e;
            end
            FN_RSV_OVL, FN_USABLE_AT, FN_USE_OVL: n_ok = r_hit;
            FN_READ: begin
                n_ok = r_read_ok;
                if (r_read_ok) begin
                    n_first  = r_m_start;
                    n_second = r_m_len;
                    n_type   = r_m_code;
                end
            end
            FN_TOTAL, FN_END, FN_ABOVE: n_first = r_acc;
            default: n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_ok     <= n_ok;
            r_o_first  <= n_first;
            r_o_second <= n_second;
            r_o_type   <= n_type;
        end
    end

    assign count32        = 32'(r_count);
    assign o_done         = r_done;
    assign o_ok           = r_o_ok;
    assign o_first_value  = r_o_first;
    assign o_second_value = r_o_second;
    assign o_region_type  = r_o_type;
    assign o_region_count = count32[RCNT_W-1:0];

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REGIONS))
        else $error("region count above table size");
    a_count_only_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.wr |=> $stable(r_count))
        else $error("region count changed without an add");
`endif

endmodule

/* design/physical_memory_region_table.sv */
// Add, read and unknown commands pass through the exec and finish states before their result word.
// Queries walk the held regions one per cycle and drain a four-stage pipeline before the result
// word; the scan state is still entered when the table is empty.
// A new command is taken only while idle; busy drops in the done cycle, so the next start
// can be taken at the edge that takes the result word, which cannot be stalled.
// Reset (synchronous, active low) empties the table and sets the usable type code to 1.
module physical_memory_region_table
    import pmrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [TYPE_W-1:0]  i_cfg_wdata,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic [ADDR_W-1:0]  i_len,
    input  logic [TYPE_W-1:0]  i_region_kind,
    input  logic [ADDR_W-1:0]  i_base,
    input  logic [ADDR_W-1:0]  i_limit,
    input  logic [INDEX_W-1:0] i_index,
    output logic               o_done,
    output logic               o_ok,
    output logic [ADDR_W-1:0]  o_first_value,
    output logic [ADDR_W-1:0]  o_second_value,
    output logic [TYPE_W-1:0]  o_region_type,
    output logic [RCNT_W-1:0]  o_region_count
);

    t_cmd    cmd;
    t_status status;

    pmrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pmrt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_addr         (i_addr),
        .i_len          (i_len),
        .i_region_kind  (i_region_kind),
        .i_base         (i_base),
        .i_limit        (i_limit),
        .i_index        (i_index),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_region_type  (o_region_type),
        .o_region_count (o_region_count)
    );

`ifndef SYNTHESIS
    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word shown while still busy");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import pmrt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [FUNC_W-1:0] FN_UNUSED_BOTTOM = 4'd9;
    localparam logic [FUNC_W-1:0] FN_UNUSED_TOP    = 4'd15;
    localparam logic [TYPE_W-1:0] PHASE_CODES [8] = '{
        32'd1, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'h5A5A_0001, 32'd3, 32'd1
    };

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  len;
        logic [TYPE_W-1:0]  region_kind;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  limit;
        logic [INDEX_W-1:0] index;
    } t_command;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] second;
        logic [TYPE_W-1:0] rtype;
        logic [RCNT_W-1:0] count;
    } t_answer;

    typedef struct packed {
        t_command cmd;
        logic     fixed;
        t_answer  want;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic               i_cfg_we      = 1'b0;
    logic [TYPE_W-1:0]  i_cfg_wdata   = '0;
    logic [FUNC_W-1:0]  i_func        = '0;
    logic [ADDR_W-1:0]  i_addr        = '0;
    logic [ADDR_W-1:0]  i_len         = '0;
    logic [TYPE_W-1:0]  i_region_kind = '0;
    logic [ADDR_W-1:0]  i_base        = '0;
    logic [ADDR_W-1:0]  i_limit       = '0;
    logic [INDEX_W-1:0] i_index       = '0;
    logic               o_done;
    logic               o_ok;
    logic [ADDR_W-1:0]  o_first_value;
    logic [ADDR_W-1:0]  o_second_value;
    logic [TYPE_W-1:0]  o_region_type;
    logic [RCNT_W-1:0]  o_region_count;

    // Shadow copy of the region table and the usable type code.
    logic [ADDR_W-1:0] held_start [MAX_REGIONS];
    logic [ADDR_W-1:0] held_len   [MAX_REGIONS];
    logic [TYPE_W-1:0] held_kind  [MAX_REGIONS];
    int                held_count = 0;
    logic [TYPE_W-1:0] usable_code = 32'd1;

    t_answer   pending_answers [$];
    t_plan_row plan [$];
    int        errors = 0;
    int        cycles = 0;
    bit        idle_ok = 1'b1;

    physical_memory_region_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_addr         (i_addr),
        .i_len          (i_len),
        .i_region_kind  (i_region_kind),
        .i_base         (i_base),
        .i_limit        (i_limit),
        .i_index        (i_index),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_region_type  (o_region_type),
        .o_region_count (o_region_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Applies one command to the shadow table and returns the answer word it produces.
    function automatic t_answer table_answer(t_command c);
        t_answer a;
        logic [ADDR_W-1:0] s, e, rb, rlen, re;
        int n;
        a = '0;
        s = '0;
        e = '0;
        n = held_count;
        case (c.func)
            FN_ADD: begin
                if (n < MAX_REGIONS) begin
                    held_start[n] = c.addr;
                    held_len[n]   = c.len;
                    held_kind[n]  = c.region_kind;
                    held_count    = n + 1;
                    a.ok          = 1'b1;
                end
            end
            FN_LARGEST: begin
                for (int i = 0; i < n; i++) begin
                    if (held_kind[i] != usable_code || held_len[i] == 0 ||
                        held_start[i] + held_len[i] <= c.base)
                        continue;
                    rb   = (held_start[i] < c.base) ? c.base : held_start[i];
                    rlen = (held_start[i] < c.base) ? held_len[i] - (c.base - held_start[i])
                                                    : held_len[i];
                    if (rb + rlen > c.limit) begin
                        if (rb >= c.limit)
                            continue;
                        rlen = c.limit - rb;
                    end
                    // Strictly greater, so the earliest region keeps a tie.
                    if (e - s < rlen) begin
                        s = rb;
                        e = rb + rlen;
                    end
                end
                a.first  = s;
                a.second = e;
                a.ok     = (e > s) && (s != 0);
            end
            FN_RSV_OVL: begin
                for (int i = 0; i < n; i++) begin
                    if (held_kind[i] == usable_code)
                        continue;
                    if (c.addr < held_start[i] + held_len[i] &&
                        held_start[i] < c.addr + c.len) begin
                        a.ok = 1'b1;
                        break;
                    end
                end
            end
            FN_USABLE_AT: begin
                for (int i = 0; i < n; i++) begin
                    if (held_kind[i] != usable_code)
                        continue;
                    if (c.addr >= held_start[i] && c.addr < held_start[i] + held_len[i]) begin
                        a.ok = 1'b1;
                        break;
                    end
                end
            end
            FN_READ: begin
                if (c.index < n) begin
                    a.ok     = 1'b1;
                    a.first  = held_start[c.index];
                    a.second = held_len[c.index];
                    a.rtype  = held_kind[c.index];
                end
            end
            FN_TOTAL: begin
                for (int i = 0; i < n; i++)
                    if (held_kind[i] == usable_code)
                        a.first += held_len[i];
            end
            FN_END: begin
                for (int i = 0; i < n; i++) begin
                    if (held_kind[i] != usable_code)
                        continue;
                    re = held_start[i] + held_len[i];
                    if (re > a.first)
                        a.first = re;
                end
            end
            FN_USE_OVL: begin
                for (int i = 0; i < n; i++) begin
                    if (held_kind[i] != usable_code)
                        continue;
                    if (held_start[i] < c.limit && held_start[i] + held_len[i] > c.base) begin
                        a.ok = 1'b1;
                        break;
                    end
                end
            end
            FN_ABOVE: begin
                for (int i = 0; i < n; i++) begin
                    if (held_kind[i] != usable_code)
                        continue;
                    re = held_start[i] + held_len[i];
                    if (re <= c.limit)
                        continue;
                    rb = (held_start[i] < c.limit) ? c.limit : held_start[i];
                    a.first += re - rb;
                end
            end
            default: ;
        endcase
        a.count = held_count[RCNT_W-1:0];
        return a;
    endfunction

    function automatic t_command cmd_of(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] addr,
                                        logic [ADDR_W-1:0] len, logic [TYPE_W-1:0] kind,
                                        logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] limit,
                                        logic [INDEX_W-1:0] index);
        t_command c;
        c.func        = f;
        c.addr        = addr;
        c.len         = len;
        c.region_kind = kind;
        c.base        = base;
        c.limit       = limit;
        c.index       = index;
        return c;
    endfunction

    function automatic t_answer answer_of(logic ok, logic [ADDR_W-1:0] first,
                                          logic [ADDR_W-1:0] second, logic [TYPE_W-1:0] rtype,
                                          logic [RCNT_W-1:0] count);
        t_answer a;
        a.ok     = ok;
        a.first  = first;
        a.second = second;
        a.rtype  = rtype;
        a.count  = count;
        return a;
    endfunction

    function automatic t_plan_row fixed_row(t_command c, t_answer want);
        t_plan_row r;
        r.cmd   = c;
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_plan_row free_row(t_command c);
        t_plan_row r;
        r.cmd   = c;
        r.fixed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Addresses near region edges, the extremes and a few random ones.
    function automatic logic [ADDR_W-1:0] pick_point();
        logic [ADDR_W-1:0] p;
        int j;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            2: p = {$urandom, $urandom};
            6: p = 64'($urandom_range(0, 4095)) << 12;
            7: p = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 65535));
            default: begin
                if (held_count == 0) begin
                    p = 64'($urandom_range(0, 4095)) << 12;
                end else begin
                    j = $urandom_range(0, held_count - 1);
                    p = held_start[j];
                    if ($urandom_range(0, 1) == 1)
                        p += held_len[j];
                    case ($urandom_range(0, 3))
                        0: p -= 1;
                        1: p += 1;
                        default: ;
                    endcase
                end
            end
        endcase
        return p;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2: return '1;
            3: return {$urandom, $urandom};
            4: return (held_count == 0) ? 64'd4096 : held_len[$urandom_range(0, held_count - 1)];
            default: return 64'($urandom_range(1, 1024)) << 12;
        endcase
    endfunction

    function automatic logic [TYPE_W-1:0] pick_kind();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1, 2, 3: return 32'd1;
            4: return 32'd2;
            5: return 32'd3;
            6: return 32'hFFFF_FFFF;
            7: return usable_code;
            default: return $urandom;
        endcase
    endfunction

    // Unused command codes, spread over the whole unused range.
    function automatic logic [FUNC_W-1:0] pick_unused();
        return FUNC_W'($urandom_range(int'(FN_UNUSED_BOTTOM), int'(FN_UNUSED_TOP)));
    endfunction

    function automatic t_command random_cmd();
        t_command c;
        int roll;
        c.func        = FN_READ;
        c.addr        = {$urandom, $urandom};
        c.len         = {$urandom, $urandom};
        c.region_kind = $urandom;
        c.base        = {$urandom, $urandom};
        c.limit       = {$urandom, $urandom};
        c.index       = INDEX_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < ((held_count < MAX_REGIONS) ? 4 : 2)) begin
            c.func = FN_ADD;
            case ($urandom_range(0, 9))
                0: c.addr = '0;
                1, 2: c.addr = {$urandom, $urandom};
                3: c.addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
                default: c.addr = 64'($urandom_range(0, 4095)) << 12;
            endcase
            c.len         = pick_span();
            c.region_kind = pick_kind();
        end else if (roll >= 97) begin
            c.func = pick_unused();
        end else begin
            c.func  = FUNC_W'($urandom_range(int'(FN_LARGEST), int'(FN_ABOVE)));
            c.addr  = pick_point();
            c.len   = pick_span();
            c.base  = pick_point();
            c.limit = ($urandom_range(0, 3) == 0) ? c.base + pick_span() : pick_point();
            if (held_count > 0 && $urandom_range(0, 1) == 1)
                c.index = INDEX_W'($urandom_range(0, held_count));
        end
        return c;
    endfunction

    task automatic issue(t_command c, logic fixed, t_answer want);
        t_answer predicted;
        bit      offered;
        offered       = !(idle_ok && $urandom_range(0, 99) < 14);
        start         <= offered;
        i_func        <= c.func;
        i_addr        <= c.addr;
        i_len         <= c.len;
        i_region_kind <= c.region_kind;
        i_base        <= c.base;
        i_limit       <= c.limit;
        i_index       <= c.index;
        @(posedge i_clk);
        // The word is taken at the first edge where start was high and busy low.
        while (!(offered && busy === 1'b0)) begin
            offered = !(idle_ok && $urandom_range(0, 99) < 14);
            start   <= offered;
            @(posedge i_clk);
        end
        predicted = table_answer(c);
        pending_answers.push_back(fixed ? want : predicted);
    endtask

    // The type code is only changed once every answer word is back.
    task automatic set_usable(logic [TYPE_W-1:0] code);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        usable_code = code;
    endtask

    always @(posedge i_clk) begin : answer_check
        t_answer want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_answers.size() == 0) begin
                $error("answer word with no command outstanding");
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0h, got %0h", want.ok, o_ok);
                    errors++;
                end
                if (o_first_value !== want.first) begin
                    $error("first_value: expected %h, got %h", want.first, o_first_value);
                    errors++;
                end
                if (o_second_value !== want.second) begin
                    $error("second_value: expected %h, got %h", want.second, o_second_value);
                    errors++;
                end
                if (o_region_type !== want.rtype) begin
                    $error("region_type: expected %h, got %h", want.rtype, o_region_type);
                    errors++;
                end
                if (o_region_count !== want.count) begin
                    $error("region_count: expected %0d, got %0d", want.count, o_region_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        // Queries on the empty table, then a small table with edge cases.
        plan.push_back(fixed_row(cmd_of(FN_READ, 0, 0, 0, 0, 0, 0), answer_of(0, 0, 0, 0, 0)));
        plan.push_back(fixed_row(cmd_of(FN_LARGEST, 0, 0, 0, 0, '1, 0),
                                 answer_of(0, 0, 0, 0, 0)));
        plan.push_back(fixed_row(cmd_of(FN_TOTAL, 0, 0, 0, 0, 0, 0), answer_of(0, 0, 0, 0, 0)));
        plan.push_back(fixed_row(cmd_of(FN_UNUSED_TOP, '1, '1, '1, '1, '1, '1),
                                 answer_of(0, 0, 0, 0, 0)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 64'h1000, 64'h9000, 1, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 1)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, '1, '1, 32'hFFFF_FFFF, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 2)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 0, 64'h800, 1, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 3)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 64'h10_0000, 64'h10_0000, 1, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 4)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 64'h20_0000, 64'h10_0000, 1, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 5)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 64'h18_0000, 64'h1_0000, 2, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 6)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 1, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 7)));
        plan.push_back(fixed_row(cmd_of(FN_ADD, 64'h5000, 0, 1, 0, 0, 0),
                                 answer_of(1, 0, 0, 0, 8)));
        plan.push_back(fixed_row(cmd_of(FN_READ, 0, 0, 0, 0, 0, 0),
                                 answer_of(1, 64'h1000, 64'h9000, 1, 8)));
        plan.push_back(fixed_row(cmd_of(FN_READ, 0, 0, 0, 0, 0, 63), answer_of(0, 0, 0, 0, 8)));
        plan.push_back(fixed_row(cmd_of(FN_READ, 0, 0, 0, 0, 0, 8), answer_of(0, 0, 0, 0, 8)));
        plan.push_back(fixed_row(cmd_of(FN_READ, 0, 0, 0, 0, 0, 7),
                                 answer_of(1, 64'h5000, 0, 1, 8)));
        plan.push_back(free_row(cmd_of(FN_LARGEST, 0, 0, 0, 0, 64'h800, 0)));
        plan.push_back(free_row(cmd_of(FN_LARGEST, 0, 0, 0, 64'h18_0000, 64'h28_0000, 0)));
        plan.push_back(free_row(cmd_of(FN_LARGEST, 0, 0, 0, 0, '1, 0)));
        plan.push_back(free_row(cmd_of(FN_RSV_OVL, 64'h18_0800, 64'h10, 0, 0, 0, 0)));
        plan.push_back(free_row(cmd_of(FN_RSV_OVL, '1, 1, 0, 0, 0, 0)));
        plan.push_back(free_row(cmd_of(FN_USABLE_AT, 64'h9FFF, 0, 0, 0, 0, 0)));
        plan.push_back(free_row(cmd_of(FN_TOTAL, 0, 0, 0, 0, 0, 0)));
        plan.push_back(free_row(cmd_of(FN_END, 0, 0, 0, 0, 0, 0)));
        plan.push_back(free_row(cmd_of(FN_USE_OVL, 0, 0, 0, 64'hA000, 64'h10_0000, 0)));
        plan.push_back(free_row(cmd_of(FN_ABOVE, 0, 0, 0, 0, 64'h15_0000, 0)));
        plan.push_back(fixed_row(cmd_of(FN_UNUSED_BOTTOM, 0, 0, 0, 0, 0, 0),
                                 answer_of(0, 0, 0, 0, 8)));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_usable(32'd1);

        foreach (plan[r])
            issue(plan[r].cmd, plan[r].fixed, plan[r].want);

        // Each phase sets a usable type code before it runs; one phase never idles.
        for (int p = 0; p < 8; p++) begin
            set_usable(PHASE_CODES[p]);
            idle_ok = (p != 3);
            for (int k = 0; k < 100; k++)
                issue(random_cmd(), 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
